>>> rtl/d2q9_bgk_collision_top_assert.svh
// ----------------------------------------------------------------------------
// D2Q9 collision assertion macros
// Shared concurrent assertion forms for the D2Q9 BGK collision block.
// ----------------------------------------------------------------------------
`ifndef D2Q9_BGK_COLLISION_TOP_ASSERT_SVH
`define D2Q9_BGK_COLLISION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define D2Q9_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("d2q9 collision assertion failed");
`define D2Q9_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("d2q9 collision assertion failed");
`else
`define D2Q9_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define D2Q9_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/d2q9_pkg.sv
// ----------------------------------------------------------------------------
// D2Q9 collision package
// Widths, types, lattice constants and helper functions of the collision block.
// ----------------------------------------------------------------------------
package d2q9_pkg;

	localparam int FW      = 20;
	localparam int NDIR    = 9;
	localparam int PW      = FW + 1;
	localparam int RSW     = 24;
	localparam int JW      = 23;
	localparam int NW      = 38;
	localparam int CW      = NW + 2;
	localparam int DIV_QB  = 21;
	localparam int CUW     = 22;
	localparam int CSQW    = 42;
	localparam int USQW    = 41;
	localparam int P2W     = 46;
	localparam int PLW     = 29;
	localparam int PRW     = 48;
	localparam int WDW     = 53;
	localparam int D9_STG  = 4;
	localparam int Q9W     = 33;
	localparam int Q9PW    = 63;
	localparam int FEQW    = 32;
	localparam int DFW     = 33;
	localparam int MW      = 51;
	localparam int RLW     = 36;
	localparam int SATW    = 36;
	localparam int OMW     = 17;

	localparam int MOM_LAT  = 2;
	localparam int DIV_LAT  = DIV_QB + 2;
	localparam int LANE_LAT = 14;
	localparam int TOTAL    = 1 + MOM_LAT + DIV_LAT + LANE_LAT;

	typedef logic signed [FW-1:0]   fix_t;
	typedef fix_t                   pops_t [NDIR];
	typedef logic signed [PW-1:0]   pair_t;
	typedef logic signed [RSW-1:0]  rsum_t;
	typedef logic signed [JW-1:0]   mom_t;
	typedef logic [NW-1:0]          num_t;
	typedef logic [CW-1:0]          cmp_t;
	typedef logic signed [CUW-1:0]  cu_t;
	typedef logic signed [CSQW-1:0] cusq_t;
	typedef logic signed [USQW-1:0] usq_t;
	typedef logic signed [P2W-1:0]  poly2_t;
	typedef logic signed [PLW-1:0]  poly_t;
	typedef logic signed [PRW-1:0]  prod_t;
	typedef logic signed [WDW-1:0]  wide_t;
	typedef logic signed [FEQW-1:0] feq_t;
	typedef logic signed [DFW-1:0]  diff_t;
	typedef logic signed [MW-1:0]   mprod_t;
	typedef logic signed [RLW-1:0]  relax_t;
	typedef logic signed [SATW-1:0] satw_t;
	typedef logic signed [1:0]      dir_t;

	typedef struct packed {
		num_t              rem;
		logic [DIV_QB-1:0] q;
		fix_t              rho;
		logic              neg;
		logic              pos;
		logic              ovf;
	} dv_t;

	localparam logic [OMW-1:0] OMEGA_RST = 17'd65536;

	localparam dir_t DIR_ZERO = 2'sd0;
	localparam dir_t DIR_POS  = 2'sd1;
	localparam dir_t DIR_NEG  = -2'sd1;

	localparam dir_t DIR_X [NDIR] = '{DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG, DIR_ZERO,
		DIR_POS, DIR_NEG, DIR_NEG, DIR_POS};
	localparam dir_t DIR_Y [NDIR] = '{DIR_ZERO, DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG,
		DIR_POS, DIR_POS, DIR_NEG, DIR_NEG};
	localparam logic [2:0] W_SHIFT [NDIR] = '{3'd4, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd0, 3'd0, 3'd0, 3'd0};

	localparam poly2_t P2_ONE     = 46'sd8589934592;
	localparam poly2_t P2_HALF    = 46'sd65536;
	localparam wide_t  FEQ_BIAS   = 53'sd1179648;
	localparam int     FEQ_SHIFT  = 18;
	// Reciprocal of nine, exact for every dividend below 2^33.
	localparam logic [29:0] Q9_MAGIC = 30'd954437177;
	localparam int     Q9_SHIFT   = 33;
	localparam mprod_t M_HALF     = 51'sd32768;
	localparam satw_t  SAT_HI     = 36'sd524287;
	localparam satw_t  SAT_LO     = -36'sd524288;

	function automatic fix_t sat_fix(input satw_t v);
		fix_t r;
		if (v > SAT_HI) begin
			r = fix_t'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = fix_t'(SAT_LO);
		end else begin
			r = fix_t'(v);
		end
		return r;
	endfunction

	function automatic cu_t dir_term(input fix_t u, input dir_t d);
		cu_t r;
		case (d)
			DIR_POS: r = cu_t'(u);
			DIR_NEG: r = -cu_t'(u);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/d2q9_moments.sv
// ----------------------------------------------------------------------------
// D2Q9 moments
// Two-stage adder tree forming density and momentum of one node.
// ----------------------------------------------------------------------------
module d2q9_moments (
	input  logic             clk,
	input  d2q9_pkg::pops_t  f,
	output d2q9_pkg::fix_t   rho,
	output d2q9_pkg::mom_t   jx,
	output d2q9_pkg::mom_t   jy
);

	d2q9_pkg::fix_t  rest_s1;
	d2q9_pkg::pair_t ew_sum_s1, ew_dif_s1, ns_sum_s1, ns_dif_s1;
	d2q9_pkg::pair_t a_sum_s1, a_dif_s1, b_sum_s1, b_dif_s1;
	d2q9_pkg::rsum_t rs;
	d2q9_pkg::fix_t  rho_s2;
	d2q9_pkg::mom_t  jx_s2, jy_s2;

	always_ff @(posedge clk) begin
		rest_s1   <= f[0];
		ew_sum_s1 <= d2q9_pkg::pair_t'(f[1]) + d2q9_pkg::pair_t'(f[3]);
		ew_dif_s1 <= d2q9_pkg::pair_t'(f[1]) - d2q9_pkg::pair_t'(f[3]);
		ns_sum_s1 <= d2q9_pkg::pair_t'(f[2]) + d2q9_pkg::pair_t'(f[4]);
		ns_dif_s1 <= d2q9_pkg::pair_t'(f[2]) - d2q9_pkg::pair_t'(f[4]);
		a_sum_s1  <= d2q9_pkg::pair_t'(f[5]) + d2q9_pkg::pair_t'(f[7]);
		a_dif_s1  <= d2q9_pkg::pair_t'(f[5]) - d2q9_pkg::pair_t'(f[7]);
		b_sum_s1  <= d2q9_pkg::pair_t'(f[6]) + d2q9_pkg::pair_t'(f[8]);
		b_dif_s1  <= d2q9_pkg::pair_t'(f[6]) - d2q9_pkg::pair_t'(f[8]);
	end

	always_comb begin
		rs = d2q9_pkg::rsum_t'(rest_s1) + d2q9_pkg::rsum_t'(ew_sum_s1)
			+ d2q9_pkg::rsum_t'(ns_sum_s1) + d2q9_pkg::rsum_t'(a_sum_s1)
			+ d2q9_pkg::rsum_t'(b_sum_s1);
	end

	always_ff @(posedge clk) begin
		rho_s2 <= d2q9_pkg::sat_fix(d2q9_pkg::satw_t'(rs));
		jx_s2  <= d2q9_pkg::mom_t'(ew_dif_s1) + d2q9_pkg::mom_t'(a_dif_s1)
			- d2q9_pkg::mom_t'(b_dif_s1);
		jy_s2  <= d2q9_pkg::mom_t'(ns_dif_s1) + d2q9_pkg::mom_t'(a_dif_s1)
			+ d2q9_pkg::mom_t'(b_dif_s1);
	end

	assign rho = rho_s2;
	assign jx  = jx_s2;
	assign jy  = jy_s2;

endmodule

>>> rtl/d2q9_div.sv
// ----------------------------------------------------------------------------
// D2Q9 velocity divider
// Pipelined restoring divider, one quotient bit per stage, with rounding
// and saturation of momentum over density.
// ----------------------------------------------------------------------------
module d2q9_div (
	input  logic           clk,
	input  d2q9_pkg::mom_t j,
	input  d2q9_pkg::fix_t rho,
	output d2q9_pkg::fix_t u
);

	d2q9_pkg::dv_t  st_q [0:d2q9_pkg::DIV_QB];
	d2q9_pkg::dv_t  st_d [1:d2q9_pkg::DIV_QB];
	d2q9_pkg::mom_t absj;
	d2q9_pkg::dv_t  fin;
	d2q9_pkg::satw_t sq;
	d2q9_pkg::fix_t u_q;
	d2q9_pkg::cmp_t  cmpv;

	assign absj = (j < 0) ? -j : j;

	always_comb begin
		for (int k = 0; k < d2q9_pkg::DIV_QB; k++) begin
			st_d[k+1] = st_q[k];
			cmpv = d2q9_pkg::cmp_t'(st_q[k].rho) << (d2q9_pkg::DIV_QB - 1 - k);
			if ({2'b00, st_q[k].rem} >= cmpv) begin
				st_d[k+1].rem = st_q[k].rem - cmpv[d2q9_pkg::NW-1:0];
				st_d[k+1].q[d2q9_pkg::DIV_QB-1-k] = 1'b1;
			end
			if (k == 0) begin
				st_d[k+1].ovf = ((st_q[k].rem >> d2q9_pkg::DIV_QB)
					>= d2q9_pkg::num_t'(st_q[k].rho));
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q[0].rem <= (d2q9_pkg::num_t'(absj) << 16)
			+ d2q9_pkg::num_t'(rho[d2q9_pkg::FW-1:1]);
		st_q[0].q   <= '0;
		st_q[0].rho <= rho;
		st_q[0].neg <= (j < 0);
		st_q[0].pos <= (rho > 0);
		st_q[0].ovf <= 1'b0;
		for (int k = 1; k <= d2q9_pkg::DIV_QB; k++) begin
			st_q[k] <= st_d[k];
		end
	end

	always_comb begin
		fin = st_q[d2q9_pkg::DIV_QB];
		sq  = fin.neg ? -d2q9_pkg::satw_t'(fin.q) : d2q9_pkg::satw_t'(fin.q);
	end

	always_ff @(posedge clk) begin
		if (!fin.pos) begin
			u_q <= '0;
		end else if (fin.ovf) begin
			u_q <= fin.neg ? d2q9_pkg::fix_t'(d2q9_pkg::SAT_LO)
				: d2q9_pkg::fix_t'(d2q9_pkg::SAT_HI);
		end else begin
			u_q <= d2q9_pkg::sat_fix(sq);
		end
	end

	assign u = u_q;

endmodule

>>> rtl/d2q9_lane.sv
// ----------------------------------------------------------------------------
// D2Q9 direction lane
// Equilibrium and BGK relaxation of one population direction.
// ----------------------------------------------------------------------------
module d2q9_lane (
	input  logic                         clk,
	input  d2q9_pkg::dir_t               dir_x,
	input  d2q9_pkg::dir_t               dir_y,
	input  logic [2:0]                   w_shift,
	input  logic [d2q9_pkg::OMW-1:0]     omega,
	input  d2q9_pkg::fix_t               ux,
	input  d2q9_pkg::fix_t               uy,
	input  d2q9_pkg::fix_t               rho,
	input  d2q9_pkg::fix_t               f,
	input  d2q9_pkg::usq_t               usq,
	output d2q9_pkg::fix_t               pop_out
);

	d2q9_pkg::cu_t    cu;
	d2q9_pkg::cu_t    cu_s1;
	d2q9_pkg::cusq_t  cusq_s1;
	d2q9_pkg::fix_t   rho_s1, rho_s2, rho_s3, rho_s4;
	d2q9_pkg::fix_t   f_dly_q [0:12];
	d2q9_pkg::poly2_t pa_s2, pb_s2, poly2_s3, pm;
	d2q9_pkg::poly_t  poly, poly_s4;
	d2q9_pkg::prod_t  prod_s5;
	d2q9_pkg::wide_t  sh, mag;
	logic [d2q9_pkg::Q9W-1:0]  x_s6;
	logic [d2q9_pkg::Q9PW-1:0] q9p_s7;
	logic [d2q9_pkg::FEQW-1:0] q9_q [0:d2q9_pkg::D9_STG-2];
	logic             neg_q [0:d2q9_pkg::D9_STG];
	d2q9_pkg::feq_t   feq;
	d2q9_pkg::diff_t  diff_s11;
	d2q9_pkg::mprod_t m_s12, mm;
	d2q9_pkg::relax_t relax, relax_s13;
	d2q9_pkg::fix_t   out_s14;

	assign cu = d2q9_pkg::dir_term(ux, dir_x) + d2q9_pkg::dir_term(uy, dir_y);

	always_ff @(posedge clk) begin
		cu_s1      <= cu;
		cusq_s1    <= d2q9_pkg::cusq_t'(cu) * d2q9_pkg::cusq_t'(cu);
		rho_s1     <= rho;
		f_dly_q[0] <= f;
		for (int i = 1; i <= 12; i++) begin
			f_dly_q[i] <= f_dly_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		pa_s2    <= d2q9_pkg::P2_ONE + (d2q9_pkg::poly2_t'(cu_s1) <<< 17)
			+ (d2q9_pkg::poly2_t'(cu_s1) <<< 18);
		pb_s2    <= (d2q9_pkg::poly2_t'(cusq_s1) <<< 3) + d2q9_pkg::poly2_t'(cusq_s1)
			- (d2q9_pkg::poly2_t'(usq) <<< 1) - d2q9_pkg::poly2_t'(usq);
		rho_s2   <= rho_s1;
		poly2_s3 <= pa_s2 + pb_s2;
		rho_s3   <= rho_s2;
	end

	always_comb begin
		pm   = (poly2_s3 < 0) ? -poly2_s3 : poly2_s3;
		pm   = (pm + d2q9_pkg::P2_HALF) >>> 17;
		poly = (poly2_s3 < 0) ? -d2q9_pkg::poly_t'(pm) : d2q9_pkg::poly_t'(pm);
	end

	always_ff @(posedge clk) begin
		poly_s4 <= poly;
		rho_s4  <= rho_s3;
		prod_s5 <= d2q9_pkg::prod_t'(rho_s4) * d2q9_pkg::prod_t'(poly_s4);
	end

	always_comb begin
		sh  = d2q9_pkg::wide_t'(prod_s5) <<< w_shift;
		mag = ((sh < 0) ? -sh : sh) + d2q9_pkg::FEQ_BIAS;
	end

	// The division by nine is a multiplication by its scaled reciprocal.
	always_ff @(posedge clk) begin
		x_s6     <= mag[d2q9_pkg::FEQ_SHIFT +: d2q9_pkg::Q9W];
		neg_q[0] <= (sh < 0);
		q9p_s7   <= d2q9_pkg::Q9PW'(x_s6) * d2q9_pkg::Q9PW'(d2q9_pkg::Q9_MAGIC);
		q9_q[0]  <= d2q9_pkg::FEQW'(q9p_s7[d2q9_pkg::Q9PW-1:d2q9_pkg::Q9_SHIFT]);
		for (int k = 1; k <= d2q9_pkg::D9_STG - 2; k++) begin
			q9_q[k] <= q9_q[k-1];
		end
		for (int k = 1; k <= d2q9_pkg::D9_STG; k++) begin
			neg_q[k] <= neg_q[k-1];
		end
	end

	always_comb begin
		feq = neg_q[d2q9_pkg::D9_STG]
			? -d2q9_pkg::feq_t'(q9_q[d2q9_pkg::D9_STG-2])
			: d2q9_pkg::feq_t'(q9_q[d2q9_pkg::D9_STG-2]);
	end

	always_ff @(posedge clk) begin
		diff_s11 <= d2q9_pkg::diff_t'(f_dly_q[9]) - d2q9_pkg::diff_t'(feq);
		m_s12    <= d2q9_pkg::mprod_t'(signed'({1'b0, omega}))
			* d2q9_pkg::mprod_t'(diff_s11);
	end

	always_comb begin
		mm    = (m_s12 < 0) ? -m_s12 : m_s12;
		mm    = (mm + d2q9_pkg::M_HALF) >>> 16;
		relax = (m_s12 < 0) ? -d2q9_pkg::relax_t'(mm) : d2q9_pkg::relax_t'(mm);
	end

	always_ff @(posedge clk) begin
		relax_s13 <= relax;
		out_s14   <= d2q9_pkg::sat_fix(d2q9_pkg::satw_t'(f_dly_q[12])
			- d2q9_pkg::satw_t'(relax_s13));
	end

	assign pop_out = out_s14;

endmodule

>>> rtl/d2q9_bgk_collision_top.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision
// Relaxes the nine populations of one lattice node toward equilibrium.
// ----------------------------------------------------------------------------
// The block takes one node on every clock cycle and returns its result after the input
// register, moment tree, dividers and lanes, with done high for one cycle. The latency is
// set mostly by the velocity divider, which resolves one quotient bit per stage,
// and then by the nine direction lanes. Busy is always low, so start may be held
// high continuously; the receiver must take every result when done is high.
// Omega is written with cfg_we and should only change while no node is in flight.
`include "d2q9_bgk_collision_top_assert.svh"

module d2q9_bgk_collision_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_we,
	input  logic [d2q9_pkg::OMW-1:0] cfg_wdata,
	input  d2q9_pkg::fix_t           pop_rest,
	input  d2q9_pkg::fix_t           pop_east,
	input  d2q9_pkg::fix_t           pop_north,
	input  d2q9_pkg::fix_t           pop_west,
	input  d2q9_pkg::fix_t           pop_south,
	input  d2q9_pkg::fix_t           pop_ne,
	input  d2q9_pkg::fix_t           pop_nw,
	input  d2q9_pkg::fix_t           pop_sw,
	input  d2q9_pkg::fix_t           pop_se,
	output logic                     done,
	output d2q9_pkg::fix_t           out_rest,
	output d2q9_pkg::fix_t           out_east,
	output d2q9_pkg::fix_t           out_north,
	output d2q9_pkg::fix_t           out_west,
	output d2q9_pkg::fix_t           out_south,
	output d2q9_pkg::fix_t           out_ne,
	output d2q9_pkg::fix_t           out_nw,
	output d2q9_pkg::fix_t           out_sw,
	output d2q9_pkg::fix_t           out_se,
	output d2q9_pkg::fix_t           density,
	output d2q9_pkg::fix_t           vel_x,
	output d2q9_pkg::fix_t           vel_y
);

	localparam int FDL = d2q9_pkg::MOM_LAT + d2q9_pkg::DIV_LAT;

	logic [d2q9_pkg::OMW-1:0]   omega_q;
	logic [d2q9_pkg::TOTAL-1:0] vld_q;
	d2q9_pkg::pops_t f_s1;
	d2q9_pkg::pops_t f_dl_q [0:FDL-1];
	d2q9_pkg::fix_t  rho_m, ux, uy;
	d2q9_pkg::mom_t  jx_m, jy_m;
	d2q9_pkg::fix_t  rho_dl_q [0:d2q9_pkg::DIV_LAT-1];
	d2q9_pkg::fix_t  rho_o_q [0:d2q9_pkg::LANE_LAT-1];
	d2q9_pkg::fix_t  ux_o_q [0:d2q9_pkg::LANE_LAT-1];
	d2q9_pkg::fix_t  uy_o_q [0:d2q9_pkg::LANE_LAT-1];
	d2q9_pkg::usq_t  usq_q;
	d2q9_pkg::pops_t pop_o;

	assign busy = 1'b0;
	assign done = vld_q[d2q9_pkg::TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= d2q9_pkg::OMEGA_RST;
			vld_q   <= '0;
		end else begin
			if (cfg_we) begin
				omega_q <= cfg_wdata;
			end
			vld_q <= {vld_q[d2q9_pkg::TOTAL-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		f_s1[0] <= pop_rest;
		f_s1[1] <= pop_east;
		f_s1[2] <= pop_north;
		f_s1[3] <= pop_west;
		f_s1[4] <= pop_south;
		f_s1[5] <= pop_ne;
		f_s1[6] <= pop_nw;
		f_s1[7] <= pop_sw;
		f_s1[8] <= pop_se;
	end

	d2q9_moments u_mom (
		.clk (clk),
		.f   (f_s1),
		.rho (rho_m),
		.jx  (jx_m),
		.jy  (jy_m)
	);

	d2q9_div u_div_x (
		.clk (clk),
		.j   (jx_m),
		.rho (rho_m),
		.u   (ux)
	);

	d2q9_div u_div_y (
		.clk (clk),
		.j   (jy_m),
		.rho (rho_m),
		.u   (uy)
	);

	always_ff @(posedge clk) begin
		f_dl_q[0]   <= f_s1;
		rho_dl_q[0] <= rho_m;
		for (int i = 1; i < FDL; i++) begin
			f_dl_q[i] <= f_dl_q[i-1];
		end
		for (int i = 1; i < d2q9_pkg::DIV_LAT; i++) begin
			rho_dl_q[i] <= rho_dl_q[i-1];
		end
		usq_q <= d2q9_pkg::usq_t'(ux) * d2q9_pkg::usq_t'(ux)
			+ d2q9_pkg::usq_t'(uy) * d2q9_pkg::usq_t'(uy);
		rho_o_q[0] <= rho_dl_q[d2q9_pkg::DIV_LAT-1];
		ux_o_q[0]  <= ux;
		uy_o_q[0]  <= uy;
		for (int i = 1; i < d2q9_pkg::LANE_LAT; i++) begin
			rho_o_q[i] <= rho_o_q[i-1];
			ux_o_q[i]  <= ux_o_q[i-1];
			uy_o_q[i]  <= uy_o_q[i-1];
		end
	end

	for (genvar g = 0; g < d2q9_pkg::NDIR; g++) begin : g_lane
		d2q9_lane u_lane (
			.clk     (clk),
			.dir_x   (d2q9_pkg::DIR_X[g]),
			.dir_y   (d2q9_pkg::DIR_Y[g]),
			.w_shift (d2q9_pkg::W_SHIFT[g]),
			.omega   (omega_q),
			.ux      (ux),
			.uy      (uy),
			.rho     (rho_dl_q[d2q9_pkg::DIV_LAT-1]),
			.f       (f_dl_q[FDL-1][g]),
			.usq     (usq_q),
			.pop_out (pop_o[g])
		);
	end

	assign out_rest  = pop_o[0];
	assign out_east  = pop_o[1];
	assign out_north = pop_o[2];
	assign out_west  = pop_o[3];
	assign out_south = pop_o[4];
	assign out_ne    = pop_o[5];
	assign out_nw    = pop_o[6];
	assign out_sw    = pop_o[7];
	assign out_se    = pop_o[8];
	assign density   = rho_o_q[d2q9_pkg::LANE_LAT-1];
	assign vel_x     = ux_o_q[d2q9_pkg::LANE_LAT-1];
	assign vel_y     = uy_o_q[d2q9_pkg::LANE_LAT-1];

	`D2Q9_ASSERT_IMPLY(a_vel_zero, clk, arst_n, done && (density <= 0), (vel_x == 0) && (vel_y == 0))
	`D2Q9_ASSERT_NEXT(a_start_tracked, clk, arst_n, start, vld_q[0])
	`D2Q9_ASSERT_NEXT(a_omega_write, clk, arst_n, cfg_we, omega_q == $past(cfg_wdata))

endmodule
